>>> rtl/dpat_pkg.sv
package dpat_pkg;

   // Field widths of the request, response and register port.
   localparam int OPCODE_W = 2;
   localparam int ADDR_W = 32;
   localparam int KIND_W = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W = 6;
   localparam int COUNT_W = 6;
   localparam int LIFE_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;

   // Default number of slots in each table.
   localparam int TABLE_DEPTH_DEF = 16;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_REMOTE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LOCAL = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK = 2'd2;

   // Response kinds.
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FORWARD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

   // Announce status codes.
   localparam logic [STATUS_W-1:0] ST_NEW = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REFRESH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_REMOTE_LIFE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_LIFE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROBE_INTERVAL = 2'd2;

   // Register reset values.
   localparam logic [LIFE_W-1:0] REMOTE_LIFE_RST = 8'd20;
   localparam logic [LIFE_W-1:0] LOCAL_LIFE_RST = 8'd10;
   localparam logic [LIFE_W-1:0] PROBE_INTERVAL_RST = 8'd5;

   // One write into a peer table: life always, address when addr_en is set.
   typedef struct packed {
      logic en;
      logic addr_en;
      logic [SLOT_W-1:0] idx;
      logic [LIFE_W-1:0] life;
      logic [ADDR_W-1:0] addr;
   } dpat_wr_type;

endpackage

>>> rtl/dpat_table.sv
module dpat_table #(
   parameter int DEPTH = dpat_pkg::TABLE_DEPTH_DEF,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic clock,
   input  logic reset,
   input  logic rd_en,
   input  logic [IW-1:0] rd_idx,
   output logic [dpat_pkg::ADDR_W-1:0] rd_addr,
   output logic [dpat_pkg::LIFE_W-1:0] rd_life,
   output logic [DEPTH-1:0] live,
   input  dpat_pkg::dpat_wr_type wr
);
   import dpat_pkg::*;

   logic [ADDR_W-1:0] addr_mem_ff [DEPTH];
   logic [LIFE_W-1:0] life_mem_ff [DEPTH];
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [LIFE_W-1:0] rd_life_ff;
   logic [DEPTH-1:0] live_ff;
   logic [IW-1:0] wr_idx;

   assign wr_idx = wr.idx[IW-1:0];

   // A slot is live while its life count is nonzero; reset frees every slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else if (wr.en) begin
         live_ff[wr_idx] <= (wr.life != '0);
      end
   end

   // Address and life memories with one registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         life_mem_ff[wr_idx] <= wr.life;
         if (wr.addr_en) begin
            addr_mem_ff[wr_idx] <= wr.addr;
         end
      end
      if (rd_en) begin
         rd_addr_ff <= addr_mem_ff[rd_idx];
         rd_life_ff <= life_mem_ff[rd_idx];
      end
   end

   assign rd_addr = rd_addr_ff;
   assign rd_life = rd_life_ff;
   assign live = live_ff;

endmodule

>>> rtl/dual_peer_aging_table.sv
// Two tables of peers, remote and local, each slot holding an address and a
// life count. A word on the req channel carries an opcode and a peer address:
// a remote hello or local reply learns the peer in its own table (refresh,
// insert into the first free slot, or report full) and is answered by one
// status word, then one forward word per live slot of the other table in
// slot order. A tick ages both tables and is answered by one report word with
// the expiry counts. rsp_last marks the final word of each request.
// The user must write registers through csr_we/csr_index/csr_wdata only
// while idle; the block itself does not enforce it. One request is in
// flight at a time; req_ready is low while it is worked. Each table is
// walked one slot per cycle, save while a forward word waits for the output
// register, through its single registered memory read port. A learn hit
// ends the learn walk early. Unused opcode 3 is dropped at once.
// Results sit in one output register; when the receiver holds rsp_ready low
// the walk pauses until the pending word is taken, so nothing is lost.
// Synchronous reset frees all slots, clears the probe holdoff and loads the
// register defaults; no clearing pass is needed.
module dual_peer_aging_table #(
   parameter int TABLE_DEPTH = dpat_pkg::TABLE_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [dpat_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [dpat_pkg::ADDR_W-1:0] req_peer_addr,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [dpat_pkg::KIND_W-1:0] rsp_kind,
   output logic [dpat_pkg::STATUS_W-1:0] rsp_status,
   output logic [dpat_pkg::SLOT_W-1:0] rsp_slot,
   output logic [dpat_pkg::ADDR_W-1:0] rsp_target_addr,
   output logic rsp_probe,
   output logic [dpat_pkg::COUNT_W-1:0] rsp_expired_remote,
   output logic [dpat_pkg::COUNT_W-1:0] rsp_expired_local,
   output logic rsp_last,
   input  logic csr_we,
   input  logic [dpat_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dpat_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dpat_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LEARN = 3'd1;
   localparam logic [2:0] S_STATUS = 3'd2;
   localparam logic [2:0] S_FWD = 3'd3;
   localparam logic [2:0] S_TICK = 3'd4;
   localparam logic [2:0] S_REPORT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [LIFE_W-1:0] remote_life_ff, local_life_ff, probe_interval_ff;
   logic [LIFE_W-1:0] holdoff_ff, holdoff_in;
   logic own_sel_ff, own_sel_in;
   logic [ADDR_W-1:0] peer_ff, peer_in;
   logic probe_ff, probe_in;
   logic [IW-1:0] iss_idx_ff, iss_idx_in;
   logic iss_on_ff, iss_on_in;
   logic [IW-1:0] ev_idx_ff, ev_idx_in;
   logic ev_on_ff, ev_on_in;
   logic free_have_ff, free_have_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [COUNT_W-1:0] exp_r_ff, exp_r_in, exp_l_ff, exp_l_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic rsp_probe_ff, rsp_probe_in;
   logic [COUNT_W-1:0] rsp_exp_r_ff, rsp_exp_r_in, rsp_exp_l_ff, rsp_exp_l_in;
   logic rsp_last_ff, rsp_last_in;

   logic rd_en;
   logic [ADDR_W-1:0] rd_addr_r, rd_addr_l;
   logic [LIFE_W-1:0] rd_life_r, rd_life_l;
   logic [TABLE_DEPTH-1:0] live_r, live_l;
   dpat_wr_type wr_r, wr_l, wr_own;

   logic [TABLE_DEPTH-1:0] own_live, other_live;
   logic [ADDR_W-1:0] own_addr, other_addr;
   logic [TABLE_DEPTH:0] live_shift;
   logic any_above, out_free, accept, adv;
   logic [LIFE_W-1:0] own_life_cfg;

   dpat_table #(.DEPTH(TABLE_DEPTH)) u_remote (
      .clock(clock), .reset(reset), .rd_en(rd_en), .rd_idx(iss_idx_ff),
      .rd_addr(rd_addr_r), .rd_life(rd_life_r), .live(live_r), .wr(wr_r)
   );

   dpat_table #(.DEPTH(TABLE_DEPTH)) u_local (
      .clock(clock), .reset(reset), .rd_en(rd_en), .rd_idx(iss_idx_ff),
      .rd_addr(rd_addr_l), .rd_life(rd_life_l), .live(live_l), .wr(wr_l)
   );

   // Steer the table being learned and the table being forwarded.
   assign own_live = own_sel_ff ? live_l : live_r;
   assign other_live = own_sel_ff ? live_r : live_l;
   assign own_addr = own_sel_ff ? rd_addr_l : rd_addr_r;
   assign other_addr = own_sel_ff ? rd_addr_r : rd_addr_l;
   assign own_life_cfg = own_sel_ff ? local_life_ff : remote_life_ff;

   // Any live slot of the other table beyond the one now evaluated.
   assign live_shift = {1'b0, other_live} >> ev_idx_ff;
   assign any_above = |live_shift[TABLE_DEPTH:1];

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         remote_life_ff <= REMOTE_LIFE_RST;
         local_life_ff <= LOCAL_LIFE_RST;
         probe_interval_ff <= PROBE_INTERVAL_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REMOTE_LIFE: remote_life_ff <= csr_wdata;
            CSR_LOCAL_LIFE: local_life_ff <= csr_wdata;
            CSR_PROBE_INTERVAL: probe_interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: issue stage then evaluate stage, one slot per cycle unless stalled on output.
   always_comb begin
      state_in = state_ff;
      holdoff_in = holdoff_ff;
      own_sel_in = own_sel_ff;
      peer_in = peer_ff;
      probe_in = probe_ff;
      iss_idx_in = iss_idx_ff;
      iss_on_in = iss_on_ff;
      ev_idx_in = ev_idx_ff;
      ev_on_in = ev_on_ff;
      free_have_in = free_have_ff;
      free_idx_in = free_idx_ff;
      status_in = status_ff;
      slot_in = slot_ff;
      exp_r_in = exp_r_ff;
      exp_l_in = exp_l_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_probe_in = rsp_probe_ff;
      rsp_exp_r_in = rsp_exp_r_ff;
      rsp_exp_l_in = rsp_exp_l_ff;
      rsp_last_in = rsp_last_ff;
      wr_r = '0;
      wr_l = '0;
      wr_own = '0;
      adv = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               own_sel_in = (req_opcode == OP_LOCAL);
               peer_in = req_peer_addr;
               probe_in = 1'b0;
               iss_idx_in = '0;
               iss_on_in = 1'b1;
               ev_on_in = 1'b0;
               free_have_in = 1'b0;
               exp_r_in = '0;
               exp_l_in = '0;
               case (req_opcode)
                  OP_REMOTE: begin
                     state_in = S_LEARN;
                     if (holdoff_ff == '0) begin
                        probe_in = 1'b1;
                        holdoff_in = probe_interval_ff;
                     end
                  end
                  OP_LOCAL: state_in = S_LEARN;
                  OP_TICK: begin
                     state_in = S_TICK;
                     if (holdoff_ff != '0) begin
                        holdoff_in = holdoff_ff - 1'b1;
                     end
                  end
                  default: iss_on_in = 1'b0;
               endcase
            end
         end

         S_LEARN: begin
            adv = 1'b1;
            if (ev_on_ff) begin
               if (own_live[ev_idx_ff] && (own_addr == peer_ff)) begin
                  // Live match: reload its life and stop the walk.
                  wr_own.en = 1'b1;
                  wr_own.idx = SLOT_W'(ev_idx_ff);
                  wr_own.life = own_life_cfg;
                  status_in = ST_REFRESH;
                  slot_in = SLOT_W'(ev_idx_ff);
                  state_in = S_STATUS;
                  adv = 1'b0;
                  iss_on_in = 1'b0;
                  ev_on_in = 1'b0;
               end else begin
                  if (!own_live[ev_idx_ff] && !free_have_ff) begin
                     free_have_in = 1'b1;
                     free_idx_in = ev_idx_ff;
                  end
                  if (!iss_on_ff) begin
                     // Last slot seen without a match: insert or report full.
                     state_in = S_STATUS;
                     adv = 1'b0;
                     ev_on_in = 1'b0;
                     if (free_have_ff || !own_live[ev_idx_ff]) begin
                        wr_own.en = 1'b1;
                        wr_own.addr_en = 1'b1;
                        wr_own.idx = free_have_ff ? SLOT_W'(free_idx_ff)
                                                  : SLOT_W'(ev_idx_ff);
                        wr_own.life = own_life_cfg;
                        wr_own.addr = peer_ff;
                        status_in = ST_NEW;
                        slot_in = wr_own.idx;
                     end else begin
                        status_in = ST_FULL;
                        slot_in = '0;
                     end
                  end
               end
            end
            if (own_sel_ff) begin
               wr_l = wr_own;
            end else begin
               wr_r = wr_own;
            end
         end

         S_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = KIND_STATUS;
               rsp_status_in = status_ff;
               rsp_slot_in = slot_ff;
               rsp_addr_in = '0;
               rsp_probe_in = probe_ff;
               rsp_exp_r_in = '0;
               rsp_exp_l_in = '0;
               rsp_last_in = ~|other_live;
               iss_idx_in = '0;
               iss_on_in = |other_live;
               ev_on_in = 1'b0;
               state_in = (|other_live) ? S_FWD : S_IDLE;
            end
         end

         S_FWD: begin
            // Pause while a live slot waits for the output register.
            adv = !(ev_on_ff && other_live[ev_idx_ff] && !out_free);
            if (adv && ev_on_ff) begin
               if (other_live[ev_idx_ff]) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in = KIND_FORWARD;
                  rsp_status_in = '0;
                  rsp_slot_in = SLOT_W'(ev_idx_ff);
                  rsp_addr_in = other_addr;
                  rsp_probe_in = 1'b0;
                  rsp_exp_r_in = '0;
                  rsp_exp_l_in = '0;
                  rsp_last_in = !any_above;
               end
               if (!iss_on_ff) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_TICK: begin
            adv = 1'b1;
            if (ev_on_ff) begin
               // Age both tables at the same slot.
               if (live_r[ev_idx_ff]) begin
                  wr_r.en = 1'b1;
                  wr_r.idx = SLOT_W'(ev_idx_ff);
                  wr_r.life = rd_life_r - 1'b1;
                  if (rd_life_r == LIFE_W'(1)) begin
                     exp_r_in = exp_r_ff + 1'b1;
                  end
               end
               if (live_l[ev_idx_ff]) begin
                  wr_l.en = 1'b1;
                  wr_l.idx = SLOT_W'(ev_idx_ff);
                  wr_l.life = rd_life_l - 1'b1;
                  if (rd_life_l == LIFE_W'(1)) begin
                     exp_l_in = exp_l_ff + 1'b1;
                  end
               end
               if (!iss_on_ff) begin
                  state_in = S_REPORT;
               end
            end
         end

         S_REPORT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = KIND_TICK;
               rsp_status_in = '0;
               rsp_slot_in = '0;
               rsp_addr_in = '0;
               rsp_probe_in = 1'b0;
               rsp_exp_r_in = exp_r_ff;
               rsp_exp_l_in = exp_l_ff;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Shared walk pointer: issue a read, then evaluate its registered result.
      rd_en = adv && iss_on_ff;
      if (adv) begin
         ev_on_in = iss_on_ff;
         ev_idx_in = iss_idx_ff;
         if (iss_on_ff) begin
            if (iss_idx_ff == LAST_IDX) begin
               iss_on_in = 1'b0;
            end else begin
               iss_idx_in = iss_idx_ff + 1'b1;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         holdoff_ff <= '0;
         iss_on_ff <= 1'b0;
         ev_on_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         holdoff_ff <= holdoff_in;
         iss_on_ff <= iss_on_in;
         ev_on_ff <= ev_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and output payload.
   always_ff @(posedge clock) begin
      own_sel_ff <= own_sel_in;
      peer_ff <= peer_in;
      probe_ff <= probe_in;
      iss_idx_ff <= iss_idx_in;
      ev_idx_ff <= ev_idx_in;
      free_have_ff <= free_have_in;
      free_idx_ff <= free_idx_in;
      status_ff <= status_in;
      slot_ff <= slot_in;
      exp_r_ff <= exp_r_in;
      exp_l_ff <= exp_l_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_probe_ff <= rsp_probe_in;
      rsp_exp_r_ff <= rsp_exp_r_in;
      rsp_exp_l_ff <= rsp_exp_l_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_target_addr = rsp_addr_ff;
   assign rsp_probe = rsp_probe_ff;
   assign rsp_expired_remote = rsp_exp_r_ff;
   assign rsp_expired_local = rsp_exp_l_ff;
   assign rsp_last = rsp_last_ff;

   // A tick report is always the final word of its request.
   a_tick_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_TICK)) |-> rsp_last_ff)
      else $error("tick report without last");

   // A full table reports slot zero.
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_STATUS) && (rsp_status_ff == ST_FULL))
      |-> (rsp_slot_ff == '0))
      else $error("full status with nonzero slot");

   // An accepted tick starts the aging walk.
   a_tick_walk: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_TICK)) |=> (state_ff == S_TICK) && iss_on_ff)
      else $error("tick did not start aging walk");

   // The evaluate stage is only busy inside a walk.
   a_walk_state: assert property (@(posedge clock) disable iff (reset)
      ev_on_ff |-> ((state_ff == S_LEARN) || (state_ff == S_FWD) || (state_ff == S_TICK)))
      else $error("walk active outside walking state");

   // A forward word targets a slot that is live in the other table.
   a_fwd_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FWD && ev_on_ff && rsp_valid_in && !(rsp_valid_ff && !rsp_ready))
      |-> other_live[ev_idx_ff])
      else $error("forward word for a free slot");

endmodule
